// ----- src/datetime_string_validator_defines.svh -----
// assertion macros shared by the datetime string validator
`ifndef DATETIME_STRING_VALIDATOR_DEFINES_SVH
`define DATETIME_STRING_VALIDATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DSV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dsv_pkg.sv -----
// types, constants and check functions of the datetime string validator
package dsv_pkg;

    // layout modes
    localparam logic [1:0] MODE_TIME     = 2'd0;
    localparam logic [1:0] MODE_DATE     = 2'd1;
    localparam logic [1:0] MODE_DATETIME = 2'd2;
    localparam logic [1:0] MODE_FRAC     = 2'd3;

    // separator characters
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // slot positions of the joined layout
    localparam logic [5:0] TIME_OFFSET = 6'd11;
    localparam logic [5:0] LAST_SLOT   = 6'd22;
    localparam logic [5:0] LIMIT_DATE  = 6'd10;
    localparam logic [5:0] LIMIT_TIME  = 6'd19;
    localparam logic [5:0] LIMIT_FRAC  = 6'd23;
    localparam logic [5:0] END_FRAC_LO = 6'd21;
    localparam logic [4:0] POS_MAX     = 5'd31;

    typedef enum logic [3:0] {
        SK_YEAR, SK_MONTH, SK_DAY, SK_HOUR, SK_MIN, SK_SEC, SK_FRAC,
        SK_DASH, SK_SPACE, SK_COLON, SK_DOT
    } t_slot;

    // per-string state; year is kept as four bcd digits
    typedef struct packed {
        logic [4:0]  position;
        logic        failed;
        logic [15:0] year_bcd;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [1:0]  frac_cnt;
    } t_dsv_state;

    // slot kind of "YYYY-MM-DD hh:mm:ss.fff"
    function automatic t_slot slot_kind(input logic [4:0] idx);
        t_slot k;
        case (idx)
            5'd0, 5'd1, 5'd2, 5'd3: k = SK_YEAR;
            5'd4, 5'd7:             k = SK_DASH;
            5'd5, 5'd6:             k = SK_MONTH;
            5'd8, 5'd9:             k = SK_DAY;
            5'd10:                  k = SK_SPACE;
            5'd11, 5'd12:           k = SK_HOUR;
            5'd13, 5'd16:           k = SK_COLON;
            5'd14, 5'd15:           k = SK_MIN;
            5'd17, 5'd18:           k = SK_SEC;
            5'd19:                  k = SK_DOT;
            default:                k = SK_FRAC;
        endcase
        return k;
    endfunction

    // times ten plus digit, kept to seven bits
    function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
        logic [10:0] w;
        w = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {7'd0, d};
        return w[6:0];
    endfunction

    // two bcd digits ab, value mod 4
    function automatic logic [1:0] pair_mod4(input logic [3:0] a, input logic [3:0] b);
        logic [1:0] m;
        m = {a[0], 1'b0} + b[1:0];
        return m;
    endfunction

    function automatic logic leap_year(input logic [15:0] y);
        logic div4, div100, div400;
        div4   = (pair_mod4(y[7:4], y[3:0]) == 2'd0);
        div100 = (y[7:0] == 8'h00);
        div400 = div100 && (pair_mod4(y[15:12], y[11:8]) == 2'd0);
        return div400 || (div4 && !div100);
    endfunction

    function automatic logic date_legal(input logic [15:0] y, input logic [6:0] m,
                                        input logic [6:0] d);
        logic ok;
        ok = (y != 16'd0) && (m >= 7'd1) && (m <= 7'd12) && (d >= 7'd1) && (d <= 7'd31);
        if (m == 7'd2) begin
            ok = ok && (leap_year(y) ? (d < 7'd30) : (d < 7'd29));
        end else if (m == 7'd4 || m == 7'd6 || m == 7'd9 || m == 7'd11) begin
            ok = ok && (d != 7'd31);
        end
        return ok;
    endfunction

    function automatic logic time_legal(input logic [6:0] h, input logic [6:0] mi,
                                        input logic [6:0] s);
        return (h <= 7'd23) && (mi <= 7'd59) && (s <= 7'd59);
    endfunction

endpackage

// ----- src/dsv_char_step.sv -----
// per-character layout check, field collection and end-of-string verdict
module dsv_char_step (
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_char_code,
    input  dsv_pkg::t_dsv_state i_state,
    output dsv_pkg::t_dsv_state o_state,
    output logic                o_verdict
);
    import dsv_pkg::*;

    logic [5:0] offset;
    logic [5:0] idx;
    logic [5:0] limit;
    logic [5:0] end_pos;
    logic       is_digit;
    logic [3:0] digit;
    logic       date_ok;
    logic       time_ok;

    // slot index and reach of the selected layout
    always_comb begin
        offset = (i_mode == MODE_TIME) ? TIME_OFFSET : 6'd0;
        idx    = {1'b0, i_state.position} + offset;
        unique case (i_mode)
            MODE_DATE: limit = LIMIT_DATE;
            MODE_FRAC: limit = LIMIT_FRAC;
            default:   limit = LIMIT_TIME;
        endcase
        is_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        digit    = is_digit ? i_char_code[3:0] : 4'd0;
    end

    // state update for one character
    always_comb begin
        o_state = i_state;
        if (i_state.position != POS_MAX) begin
            o_state.position = i_state.position + 5'd1;
        end
        if (!i_state.failed) begin
            if (idx >= limit || idx > LAST_SLOT) begin
                o_state.failed = 1'b1;
            end else begin
                case (slot_kind(idx[4:0]))
                    SK_DASH:  o_state.failed = (i_char_code != CH_DASH);
                    SK_SPACE: o_state.failed = (i_char_code != CH_SPACE);
                    SK_COLON: o_state.failed = (i_char_code != CH_COLON);
                    SK_DOT:   o_state.failed = (i_char_code != CH_DOT);
                    SK_YEAR:  o_state.year_bcd = {i_state.year_bcd[11:0], digit};
                    SK_MONTH: o_state.month  = acc7(i_state.month, digit);
                    SK_DAY:   o_state.day    = acc7(i_state.day, digit);
                    SK_HOUR:  o_state.hour   = acc7(i_state.hour, digit);
                    SK_MIN:   o_state.minute = acc7(i_state.minute, digit);
                    SK_SEC:   o_state.second = acc7(i_state.second, digit);
                    default: begin
                        if (i_state.frac_cnt != 2'd3) begin
                            o_state.frac_cnt = i_state.frac_cnt + 2'd1;
                        end
                    end
                endcase
                // digit slots fail on anything but 0..9
                if (!is_digit && slot_kind(idx[4:0]) != SK_DASH
                        && slot_kind(idx[4:0]) != SK_SPACE
                        && slot_kind(idx[4:0]) != SK_COLON
                        && slot_kind(idx[4:0]) != SK_DOT) begin
                    o_state.failed = 1'b1;
                end
            end
        end
    end

    // verdict on the updated state, used when this is the last character
    always_comb begin
        end_pos = {1'b0, o_state.position} + offset;
        date_ok = date_legal(o_state.year_bcd, o_state.month, o_state.day);
        time_ok = time_legal(o_state.hour, o_state.minute, o_state.second);
        unique case (i_mode)
            MODE_TIME:     o_verdict = (end_pos == LIMIT_TIME) && time_ok;
            MODE_DATE:     o_verdict = (end_pos == LIMIT_DATE) && date_ok;
            MODE_DATETIME: o_verdict = (end_pos == LIMIT_TIME) && date_ok && time_ok;
            default:       o_verdict = (end_pos >= END_FRAC_LO) && (end_pos <= LIMIT_FRAC)
                                       && (o_state.frac_cnt != 2'd0) && date_ok && time_ok;
        endcase
        o_verdict = o_verdict && !o_state.failed;
    end

endmodule

// ----- src/datetime_string_validator.sv -----
// datetime string validator: top level with handshake, state and result registers
//
// Input channel: one ASCII character per beat (i_char_code) with i_is_last
// marking the end of a string; accepted when i_valid and o_ready are high.
// Output channel: one beat per string (o_valid_res), given for the beat that
// carried i_is_last; taken when o_valid and i_ready are high.
// Configuration: i_cfg_we writes i_cfg_data into the layout mode
// (0 hh:mm:ss, 1 YYYY-MM-DD, 2 joined, 3 joined with 1 to 3 fraction digits).
// Path: a last character is held in the input register, and the character step
// then writes its verdict into the result register, which drives o_valid.
// Throughput: one character per cycle while o_ready is high; the character
// step is one pass of compare and digit accumulate, and the verdict is a few
// compares on it.
// Reset: mode returns to 2, string state and both stages are cleared.
// Stall: while a result waits, characters that are not last keep flowing;
// a last character waits in the input register, and o_ready drops once
// that register cannot move.
`include "datetime_string_validator_defines.svh"

module datetime_string_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_valid_res
);
    import dsv_pkg::*;

    logic [1:0] r_mode;
    logic       r_s1_valid;
    logic       r_s1_last;
    logic [7:0] r_s1_char;
    logic [1:0] r_s1_mode;
    t_dsv_state r_state;
    logic       r_out_valid;
    logic       r_out_res;

    t_dsv_state n_state;
    logic       verdict;
    logic       out_free;
    logic       s1_go;
    logic       in_beat;

    logic       last_go;
    logic       out_stalled;
    logic       state_clear;
    logic       has_pos;

    // handshake between the stages
    always_comb begin
        out_free = !r_out_valid || i_ready;
        s1_go    = r_s1_valid && (!r_s1_last || out_free);
        o_ready  = !r_s1_valid || s1_go;
        in_beat  = i_valid && o_ready;
    end

    dsv_char_step u_step (
        .i_mode      (r_s1_mode),
        .i_char_code (r_s1_char),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_verdict   (verdict)
    );

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DATETIME;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_char <= i_char_code;
            r_s1_last <= i_is_last;
            r_s1_mode <= r_mode;
        end
    end

    // string state, cleared after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_go) begin
            r_state <= r_s1_last ? '0 : n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out_res <= verdict;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_valid_res = r_out_res;

    // terms used by the checks
    assign last_go     = s1_go && r_s1_last;
    assign out_stalled = r_out_valid && !i_ready && r_s1_valid && r_s1_last;
    assign state_clear = (r_state.position == 5'd0) && !r_state.failed;
    assign has_pos     = (r_state.position != 5'd0);

    // a last character always lands a result beat
    `DSV_ASSERT_NEXT(a_last_gives_beat, i_clk, i_rst_n, last_go, r_out_valid, "no result beat")
    // a waiting result is never overwritten
    `DSV_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, out_stalled, !s1_go, "result overwritten")
    // string state restarts after each result
    `DSV_ASSERT_NEXT(a_state_cleared, i_clk, i_rst_n, last_go, state_clear, "state not cleared")
    // a failure is only ever recorded after some character
    `DSV_ASSERT_SAME(a_fail_has_pos, i_clk, i_rst_n, r_state.failed, has_pos, "no character seen")

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for the datetime string validator: directed layouts, stalls and random strings
`timescale 1ns / 1ps

module tb_top;
    import dsv_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 12;
    localparam int IDLE_PERCENT  = 19;

    // joined layout, one byte per slot, slot 0 in the top byte
    localparam logic [8*23-1:0] LAYOUT = "YYYY-MM-DD hh:mm:ss.fff";

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_data  = MODE_DATETIME;
    logic       i_valid     = 1'b0;
    logic [7:0] i_char_code = 8'h00;
    logic       i_is_last   = 1'b0;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_valid_res;

    // mirror of the block's mode and per-string state
    logic [1:0]  cur_mode = MODE_DATETIME;
    logic [4:0]  pos_cnt  = '0;
    logic        bad      = 1'b0;
    logic [13:0] year_v   = '0;
    logic [6:0]  month_v  = '0;
    logic [6:0]  day_v    = '0;
    logic [6:0]  hour_v   = '0;
    logic [6:0]  minute_v = '0;
    logic [6:0]  second_v = '0;
    logic [1:0]  frac_cnt = '0;

    logic       verdict_q[$];
    logic       want_res;
    logic [7:0] text_q[$];

    int  mismatch_count = 0;
    int  beats_sent     = 0;
    int  cycle_count    = 0;
    int  stall_request  = 0;
    int  stall_left     = 0;
    bit  quiet_tx       = 1'b0;
    bit  quiet_rx       = 1'b0;

    datetime_string_validator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_valid_res (o_valid_res)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // calendar and clock legality
    function automatic bit is_leap(input int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic bit calendar_ok(input int y, input int m, input int d);
        if (y == 0 || m < 1 || m > 12 || d < 1 || d > 31) return 1'b0;
        if (m == 2) return d <= (is_leap(y) ? 29 : 28);
        if (m == 4 || m == 6 || m == 9 || m == 11) return d <= 30;
        return 1'b1;
    endfunction

    function automatic bit clock_ok(input int h, input int mi, input int s);
        return (h <= 23) && (mi <= 59) && (s <= 59);
    endfunction

    // advance the mirrored state by one accepted character
    task automatic predict_beat(input logic [7:0] c, input logic last);
        int         idx;
        int         limit;
        int         fin;
        logic [7:0] kind;
        logic       is_dig;
        logic [3:0] dg;
        logic       ok;
        idx    = pos_cnt + ((cur_mode == MODE_TIME) ? 11 : 0);
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        dg     = is_dig ? 4'(c - CH_ZERO) : 4'd0;
        limit  = (cur_mode == MODE_DATE) ? 10 : ((cur_mode == MODE_FRAC) ? 23 : 19);
        if (pos_cnt != 5'd31) pos_cnt++;
        if (!bad) begin
            if (idx >= limit || idx > 22) begin
                bad = 1'b1;
            end else begin
                kind = LAYOUT[8*(22-idx) +: 8];
                if (kind == CH_DASH || kind == CH_SPACE || kind == CH_COLON || kind == CH_DOT) begin
                    if (c != kind) bad = 1'b1;
                end else if (!is_dig) begin
                    bad = 1'b1;
                end else begin
                    case (kind)
                        "Y":     year_v   = year_v * 14'd10 + {10'd0, dg};
                        "M":     month_v  = month_v * 7'd10 + {3'd0, dg};
                        "D":     day_v    = day_v * 7'd10 + {3'd0, dg};
                        "h":     hour_v   = hour_v * 7'd10 + {3'd0, dg};
                        "m":     minute_v = minute_v * 7'd10 + {3'd0, dg};
                        "s":     second_v = second_v * 7'd10 + {3'd0, dg};
                        default: if (frac_cnt != 2'd3) frac_cnt++;
                    endcase
                end
            end
        end
        if (last) begin
            fin = pos_cnt + ((cur_mode == MODE_TIME) ? 11 : 0);
            case (cur_mode)
                MODE_TIME: ok = (fin == 19) && clock_ok(hour_v, minute_v, second_v);
                MODE_DATE: ok = (fin == 10) && calendar_ok(year_v, month_v, day_v);
                MODE_DATETIME: ok = (fin == 19) && calendar_ok(year_v, month_v, day_v)
                                    && clock_ok(hour_v, minute_v, second_v);
                default: ok = (fin >= 21) && (fin <= 23) && (frac_cnt != 2'd0)
                              && calendar_ok(year_v, month_v, day_v)
                              && clock_ok(hour_v, minute_v, second_v);
            endcase
            verdict_q.push_back(!bad && ok);
            pos_cnt  = '0;
            bad      = 1'b0;
            year_v   = '0;
            month_v  = '0;
            day_v    = '0;
            hour_v   = '0;
            minute_v = '0;
            second_v = '0;
            frac_cnt = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic want, input logic got);
        $display("mismatch at cycle %0d: %s, expected %0d, got %0d", cycle_count, what, want, got);
        mismatch_count++;
    endtask

    // one character beat, with random gaps before it
    task automatic send_beat(input logic [7:0] c, input logic last);
        while (!quiet_tx && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_is_last   <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_beat(c, last);
        beats_sent++;
    endtask

    task automatic send_text(input string s, input logic last);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], last && (i == s.len() - 1));
    endtask

    task automatic send_queue();
        for (int i = 0; i < text_q.size(); i++) send_beat(text_q[i], i == text_q.size() - 1);
    endtask

    // mode write once the block has gone quiet
    task automatic set_mode(input logic [1:0] m);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_data <= m;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = m;
    endtask

    task automatic push_number(input int value, input int digits);
        int div;
        div = 1;
        for (int i = 1; i < digits; i++) div *= 10;
        for (int i = 0; i < digits; i++) begin
            text_q.push_back(CH_ZERO + 8'((value / div) % 10));
            div /= 10;
        end
    endtask

    // well-formed string of the current layout with random, mostly legal, values
    task automatic build_wellformed();
        int yr;
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)       yr = 0;
        else if (pick < 10) yr = 2000;
        else if (pick < 16) yr = 1900;
        else if (pick < 24) yr = 2024;
        else                yr = $urandom_range(9999);
        text_q.delete();
        if (cur_mode != MODE_TIME) begin
            push_number(yr, 4);
            text_q.push_back(CH_DASH);
            push_number(($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(99), 2);
            text_q.push_back(CH_DASH);
            push_number(($urandom_range(99) < 80) ? $urandom_range(1, 31) : $urandom_range(99), 2);
        end
        if (cur_mode == MODE_DATETIME || cur_mode == MODE_FRAC) text_q.push_back(CH_SPACE);
        if (cur_mode != MODE_DATE) begin
            push_number(($urandom_range(99) < 85) ? $urandom_range(23) : $urandom_range(99), 2);
            text_q.push_back(CH_COLON);
            push_number(($urandom_range(99) < 85) ? $urandom_range(59) : $urandom_range(99), 2);
            text_q.push_back(CH_COLON);
            push_number(($urandom_range(99) < 85) ? $urandom_range(59) : $urandom_range(99), 2);
        end
        if (cur_mode == MODE_FRAC) begin
            text_q.push_back(CH_DOT);
            push_number($urandom_range(999), $urandom_range(1, 3));
        end
    endtask

    // joined layout at reset mode
    task automatic test_joined_layout();
        send_text("2024-02-29 23:59:59", 1'b1);
        send_text("2023-02-29 12:00:00", 1'b1);
        send_text("2000-02-29 00:00:00", 1'b1);
        send_text("1900-02-29 00:00:00", 1'b1);
        send_text("0000-01-01 00:00:00", 1'b1);
        send_text("9999-12-31 23:59:59", 1'b1);
        send_text("2024-13-01 00:00:00", 1'b1);
        send_text("2024-04-31 00:00:00", 1'b1);
        send_text("2024-01-00 00:00:00", 1'b1);
        send_text("2024-01-01 24:00:00", 1'b1);
        send_text("2024-01-01 00:60:00", 1'b1);
        send_text("2024-01-01 00:00:60", 1'b1);
        // too short, too long, wrong separator
        send_text("2024-01-01 12:00", 1'b1);
        send_text("2024-01-01 12:00:00Z", 1'b1);
        send_text("2024/01/01 12:00:00", 1'b1);
        // nul and all-ones bytes in digit slots
        send_text("2024-01-0", 1'b0);
        send_beat(8'h00, 1'b0);
        send_text(" 12:00:00", 1'b1);
        send_beat(8'hFF, 1'b0);
        send_text("024-01-01 12:00:00", 1'b1);
        // far past the end, position saturates
        for (int i = 0; i < 35; i++) send_beat("7", i == 34);
        send_text("9", 1'b1);
    endtask

    task automatic test_time_layout();
        set_mode(MODE_TIME);
        send_text("23:59:59", 1'b1);
        send_text("00:00:00", 1'b1);
        send_text("24:00:00", 1'b1);
        send_text("12:5a:00", 1'b1);
    endtask

    task automatic test_date_layout();
        set_mode(MODE_DATE);
        send_text("2024-02-29", 1'b1);
        send_text("2023-11-31", 1'b1);
        send_text("0001-01-01", 1'b1);
        send_text("2024-01-012", 1'b1);
    endtask

    task automatic test_fraction_layout();
        set_mode(MODE_FRAC);
        send_text("2024-06-30 10:20:30.1", 1'b1);
        send_text("2024-06-30 10:20:30.123", 1'b1);
        send_text("2024-06-30 10:20:30.1234", 1'b1);
        send_text("2024-06-30 10:20:30.", 1'b1);
        send_text("2024-06-30 10:20:30", 1'b1);
    endtask

    // layout changed partway through a string
    task automatic test_mode_switch();
        set_mode(MODE_DATE);
        send_text("2024-05-17", 1'b0);
        set_mode(MODE_DATETIME);
        send_text(" 08:09:10", 1'b1);
        set_mode(MODE_TIME);
        send_text("12:30", 1'b0);
        set_mode(MODE_FRAC);
        send_text("1:00:00.5", 1'b1);
    endtask

    // receiver holds off while short strings keep coming
    task automatic test_output_stall();
        int len;
        quiet_tx      = 1'b1;
        stall_request = 300;
        for (int s = 0; s < 40; s++) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) send_beat(8'($urandom_range(255)), i == len - 1);
        end
        quiet_tx = 1'b0;
    endtask

    task automatic test_random_strings();
        int start;
        int strings;
        int pick;
        int n;
        start   = beats_sent;
        strings = 0;
        while (beats_sent - start < 550 || strings < 30) begin
            if (strings % 8 == 0) set_mode(2'($urandom_range(3)));
            quiet_tx = (strings >= 12 && strings < 24);
            quiet_rx = quiet_tx;
            build_wellformed();
            pick = $urandom_range(99);
            if (pick < 8) begin
                text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
            end else if (pick < 13) begin
                n = $urandom_range(1, text_q.size() - 1);
                while (text_q.size() > n) void'(text_q.pop_back());
            end else if (pick < 17) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    text_q.push_back(($urandom_range(1) != 0) ? CH_ZERO + 8'($urandom_range(9))
                                                              : 8'($urandom_range(255)));
            end else if (pick < 22) begin
                text_q.delete();
                n = $urandom_range(1, 40);
                for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(255)));
            end
            send_queue();
            strings++;
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    // result beat check against the oldest verdict
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result beat with nothing pending", 1'b0, o_valid_res);
            end else begin
                want_res = verdict_q.pop_front();
                if (o_valid_res !== want_res) report_mismatch("valid_res", want_res, o_valid_res);
            end
        end
    end

    // receiver ready, with random idling and requested hold-offs
    always @(posedge i_clk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if (quiet_rx) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // timeout
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // test sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_joined_layout();
        test_time_layout();
        test_date_layout();
        test_fraction_layout();
        test_mode_switch();
        test_output_stall();
        test_random_strings();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- datetime_string_validator.f -----
+incdir+src
src/dsv_pkg.sv
src/dsv_char_step.sv
src/datetime_string_validator.sv
tb/sv/tb_top.sv
